/* rtl/fpa_pkg.sv */
// Shared constants for the fixed-point ALU: action codes, default widths,
// and field widths. No dependencies.
package fpa_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int WORD_BITS_DEF = 32;

  localparam int ACT_BITS   = 4;
  localparam int FIELD_BITS = 32;

  localparam logic [ACT_BITS-1:0] ACT_ADD = 4'd0;
  localparam logic [ACT_BITS-1:0] ACT_SUB = 4'd1;
  localparam logic [ACT_BITS-1:0] ACT_MUL = 4'd2;
  localparam logic [ACT_BITS-1:0] ACT_DIV = 4'd3;
  localparam logic [ACT_BITS-1:0] ACT_CMP = 4'd4;
  localparam logic [ACT_BITS-1:0] ACT_MIN = 4'd5;
  localparam logic [ACT_BITS-1:0] ACT_MAX = 4'd6;
  localparam logic [ACT_BITS-1:0] ACT_INC = 4'd7;
  localparam logic [ACT_BITS-1:0] ACT_DEC = 4'd8;

endpackage

/* rtl/fpa_mul.sv */
// Two-stage unsigned magnitude multiplier with round-half-up and fraction shift.
// Split into four half-width partial products. Uses no package.
module fpa_mul #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [WORD_BITS-1:0] x,
  input  logic [WORD_BITS-1:0] y,
  output logic [2*WORD_BITS:0] p
);

  localparam int W  = WORD_BITS;
  localparam int H  = (W + 1) / 2;
  localparam int HI = W - H;
  localparam int PW = 2 * W + 1;
  localparam logic [PW-1:0] HALF = (PW'(1) << FRAC_BITS) >> 1;

  logic [2*H-1:0]  pp_ll;
  logic [H+HI-1:0] pp_lh;
  logic [H+HI-1:0] pp_hl;
  logic [2*HI-1:0] pp_hh;
  logic [PW-1:0]   sum;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll <= x[H-1:0] * y[H-1:0];
      pp_lh <= (H+HI)'(x[H-1:0]) * (H+HI)'(y[W-1:H]);
      pp_hl <= (H+HI)'(x[W-1:H]) * (H+HI)'(y[H-1:0]);
      pp_hh <= x[W-1:H] * y[W-1:H];
    end
  end

  assign sum = PW'(pp_ll) + (PW'(pp_lh) << H) + (PW'(pp_hl) << H)
             + (PW'(pp_hh) << (2 * H)) + HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= sum >> FRAC_BITS;
    end
  end

endmodule

/* rtl/fpa_div.sv */
// Restoring divider, one quotient bit per pipeline stage.
// Divides (x << FRAC_BITS) by d; no package dependency.
module fpa_div #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [WORD_BITS-1:0]           x,
  input  logic [WORD_BITS-1:0]           d,
  output logic [WORD_BITS+FRAC_BITS-1:0] q,
  output logic [WORD_BITS-1:0]           r,
  output logic [WORD_BITS-1:0]           dd
);

  localparam int W = WORD_BITS;
  localparam int N = WORD_BITS + FRAC_BITS;

  logic [W-1:0] r_s [0:N];
  logic [N-1:0] n_s [0:N];
  logic [N-1:0] q_s [0:N];
  logic [W-1:0] d_s [0:N];

  assign r_s[0] = '0;
  assign n_s[0] = N'(x) << FRAC_BITS;
  assign q_s[0] = '0;
  assign d_s[0] = d;

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [W-1:0] rt;
    logic         take;
    // remainder stays below d, so its top bit is always zero
    assign rt   = {r_s[i][W-2:0], n_s[i][N-1]};
    assign take = (rt >= d_s[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        r_s[i+1] <= take ? (rt - d_s[i]) : rt;
        n_s[i+1] <= n_s[i] << 1;
        q_s[i+1] <= {q_s[i][N-2:0], take};
        d_s[i+1] <= d_s[i];
      end
    end
  end

  assign q  = q_s[N];
  assign r  = r_s[N];
  assign dd = d_s[N];

endmodule

/* rtl/fixed_point_alu.sv */
// Fixed-point ALU top level: input decode, pipelined multiply and divide,
// final rounding/saturation. Depends on fpa_pkg, fpa_mul, fpa_div.
// Depth from the accepting edge to m_axis_tvalid is set by the divider, which retires
// one quotient bit per stage; the default format is Q24.8.
// Throughput: one transaction per cycle while m_axis_tready does not stall the output register.
// The whole pipeline advances together whenever the output register is empty
// or being taken. Reset (rst, synchronous) clears all valid bits.
module fixed_point_alu #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // action[3:0], operand_a[35:4], operand_b[67:36]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // result_raw[31:0], a_less, a_greater, a_equal, error
);

  localparam int W  = WORD_BITS;
  localparam int N  = WORD_BITS + FRAC_BITS;
  localparam int PW = 2 * W + 1;
  localparam int MW = (N + 1 > PW) ? N + 1 : PW;
  localparam int FB = fpa_pkg::FIELD_BITS;

  localparam logic [MW-1:0] LIM_N = MW'(1) << (W - 1);
  localparam logic [MW-1:0] LIM_P = LIM_N - MW'(1);
  localparam logic [W-1:0]  WMIN  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0]  WMAX  = {1'b0, {(W-1){1'b1}}};

  typedef struct packed {
    logic [fpa_pkg::ACT_BITS-1:0] act;
    logic [W-1:0]                 a;
    logic [W-1:0]                 b;
    logic                         lt;
    logic                         gt;
    logic                         eq;
    logic                         neg;
    logic [W-1:0]                 res;
    logic                         err;
  } ctrl_t;

  // returns {error, value}
  function automatic logic [W:0] saturate(input logic [MW-1:0] m, input logic ng);
    logic [W-1:0] v;
    logic         over;
    v    = ng ? (~m[W-1:0] + W'(1)) : m[W-1:0];
    over = ng ? (m > LIM_N) : (m > LIM_P);
    if (over) begin
      v = ng ? WMIN : WMAX;
    end
    return {over, v};
  endfunction

  logic                         en;
  logic [fpa_pkg::ACT_BITS-1:0] action;
  logic signed [FB-1:0]         operand_a;
  logic signed [FB-1:0]         operand_b;
  logic signed [W-1:0]          a_w;
  logic signed [W-1:0]          b_w;
  logic [W-1:0]                 sum_ab;
  logic [W-1:0]                 dif_ab;
  logic [W-1:0]                 inc_a;
  logic [W-1:0]                 dec_a;
  logic [W-1:0]                 sat_a;
  ctrl_t                        front;

  ctrl_t        c [0:N];
  logic         v [0:N];
  logic [W-1:0] x0;
  logic [W-1:0] y0;

  logic [PW-1:0] mp [0:N-2];
  logic [N-1:0]  dq;
  logic [W-1:0]  dr;
  logic [W-1:0]  dd;
  logic [N:0]    dq_r;
  logic [W:0]    mul_out;
  logic [W:0]    div_out;

  logic [W-1:0] result;
  logic         res_err;
  logic [W-1:0] out_res;
  logic         out_lt;
  logic         out_gt;
  logic         out_eq;
  logic         out_err;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign action    = s_axis_tdata[3:0];
  assign operand_a = s_axis_tdata[35:4];
  assign operand_b = s_axis_tdata[67:36];
  assign a_w       = W'(operand_a);
  assign b_w       = W'(operand_b);

  assign sum_ab = a_w + b_w;
  assign dif_ab = a_w - b_w;
  assign inc_a  = a_w + W'(1);
  assign dec_a  = a_w - W'(1);
  assign sat_a  = a_w[W-1] ? WMIN : WMAX;

  always_comb begin
    front.act = action;
    front.a   = a_w;
    front.b   = b_w;
    front.lt  = a_w < b_w;
    front.gt  = a_w > b_w;
    front.eq  = a_w == b_w;
    front.neg = a_w[W-1] ^ b_w[W-1];
    front.res = '0;
    front.err = 1'b0;
    case (action)
      fpa_pkg::ACT_ADD: begin
        front.err = (a_w[W-1] == b_w[W-1]) && (sum_ab[W-1] != a_w[W-1]);
        front.res = front.err ? sat_a : sum_ab;
      end
      fpa_pkg::ACT_SUB: begin
        front.err = (a_w[W-1] != b_w[W-1]) && (dif_ab[W-1] != a_w[W-1]);
        front.res = front.err ? sat_a : dif_ab;
      end
      fpa_pkg::ACT_CMP: front.res = a_w;
      fpa_pkg::ACT_MIN: front.res = (a_w < b_w) ? a_w : b_w;
      fpa_pkg::ACT_MAX: front.res = (a_w > b_w) ? a_w : b_w;
      fpa_pkg::ACT_INC: begin
        front.err = !a_w[W-1] && inc_a[W-1];
        front.res = front.err ? WMAX : inc_a;
      end
      fpa_pkg::ACT_DEC: begin
        front.err = a_w[W-1] && !dec_a[W-1];
        front.res = front.err ? WMIN : dec_a;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c[0] <= front;
      x0   <= a_w[W-1] ? (~a_w + W'(1)) : a_w;
      y0   <= b_w[W-1] ? (~b_w + W'(1)) : b_w;
    end
  end

  for (genvar i = 1; i <= N; i++) begin : g_ctrl
    always_ff @(posedge clk) begin
      if (en) begin
        c[i] <= c[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= N; i++) begin
        v[i] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= s_axis_tvalid;
      for (int i = 1; i <= N; i++) begin
        v[i] <= v[i-1];
      end
    end
  end

  fpa_mul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk),
    .en  (en),
    .x   (x0),
    .y   (y0),
    .p   (mp[0])
  );

  // product is ready alongside stage 2; hold it until the quotient catches up
  for (genvar i = 1; i <= N - 2; i++) begin : g_mdly
    always_ff @(posedge clk) begin
      if (en) begin
        mp[i] <= mp[i-1];
      end
    end
  end

  fpa_div #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .en  (en),
    .x   (x0),
    .d   (y0),
    .q   (dq),
    .r   (dr),
    .dd  (dd)
  );

  // round half away from zero on the magnitude: 2r >= d
  assign dq_r    = {1'b0, dq} + (N+1)'({dr, 1'b0} >= {1'b0, dd});
  assign mul_out = saturate(MW'(mp[N-2]), c[N].neg);
  assign div_out = saturate(MW'(dq_r), c[N].neg);

  always_comb begin
    result  = c[N].res;
    res_err = c[N].err;
    case (c[N].act)
      fpa_pkg::ACT_MUL: begin
        result  = mul_out[W-1:0];
        res_err = mul_out[W];
      end
      fpa_pkg::ACT_DIV: begin
        if (c[N].b == '0) begin
          res_err = 1'b1;
          if (c[N].a == '0) begin
            result = '0;
          end else begin
            result = c[N].a[W-1] ? WMIN : WMAX;
          end
        end else begin
          result  = div_out[W-1:0];
          res_err = div_out[W];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= v[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res <= result;
      out_lt  <= c[N].lt;
      out_gt  <= c[N].gt;
      out_eq  <= c[N].eq;
      out_err <= res_err;
    end
  end

  assign m_axis_tdata = {4'b0, out_err, out_eq, out_gt, out_lt, FB'($signed(out_res))};

endmodule

/* sim/tb_top.sv */
// Self-checking bench for fixed_point_alu (Q24.8): directed and random actions
// checked against an exact-arithmetic predictor. Depends on fpa_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = fpa_pkg::FRAC_BITS_DEF;
  localparam longint MAXW = 64'sd2147483647;
  localparam longint MINW = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] res;
    logic lt, gt, eq, err;
  } alu_result_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [39:0] m_axis_tdata;

  alu_result_t expected_q[$];
  int mismatches = 0;
  int cycles = 0;
  int hold_off = 0;
  bit hold_req = 0;
  bit hold_taken = 0;
  bit done = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  fixed_point_alu DUT (.*);

  function automatic alu_result_t alu_predict(logic [3:0] act, logic signed [31:0] a,
                                              logic signed [31:0] b);
    alu_result_t r;
    longint sa, sb, t, q, rem, ma, mb;
    logic [127:0] mp, lim;
    logic neg;
    sa = a;
    sb = b;
    r.lt = sa < sb;
    r.gt = sa > sb;
    r.eq = sa == sb;
    r.err = 0;
    t = 0;
    case (act)
      fpa_pkg::ACT_ADD: t = sa + sb;
      fpa_pkg::ACT_SUB: t = sa - sb;
      fpa_pkg::ACT_INC: t = sa + 1;
      fpa_pkg::ACT_DEC: t = sa - 1;
      fpa_pkg::ACT_CMP: t = sa;
      fpa_pkg::ACT_MIN: t = r.lt ? sa : sb;
      fpa_pkg::ACT_MAX: t = r.gt ? sa : sb;
      fpa_pkg::ACT_MUL: begin
        neg = (sa < 0) != (sb < 0);
        ma = sa < 0 ? -sa : sa;
        mb = sb < 0 ? -sb : sb;
        mp = (128'(ma) * 128'(mb) + (128'd1 << (FB - 1))) >> FB;
        lim = neg ? 128'd2147483648 : 128'd2147483647;
        if (mp > lim) t = neg ? MINW : MAXW + 1;
        else t = neg ? -longint'(mp) : longint'(mp);
        if (mp > lim) r.err = 1;
      end
      fpa_pkg::ACT_DIV: begin
        if (sb == 0) begin
          r.err = 1;
          t = sa > 0 ? MAXW : (sa < 0 ? MINW : 0);
        end else begin
          neg = (sa < 0) != (sb < 0);
          ma = (sa < 0 ? -sa : sa) <<< FB;
          mb = sb < 0 ? -sb : sb;
          q = ma / mb;
          rem = ma % mb;
          if (rem >= mb - rem) q++;
          t = neg ? -q : q;
        end
      end
      default: t = 0;
    endcase
    if (t > MAXW) begin t = MAXW; r.err = 1; end
    if (t < MINW) begin t = MINW; r.err = 1; end
    r.res = t[31:0];
    return r;
  endfunction

  // sender: bursts with random gaps
  int burst_left = 0;
  task automatic send_op(logic [3:0] act, logic [31:0] a, logic [31:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1;
    s_axis_tdata <= {4'b0, b, a, act};
    do @(posedge clk); while (!s_axis_tready);
    expected_q.push_back(alu_predict(act, a, b));
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                     : 32'h80000000 + $urandom_range(0, 3);
      1: return 32'($signed($urandom_range(0, 2048)) - 1024);
      2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] vals[6] = '{32'h0, 32'h100, 32'hffffff00, 32'h7fffffff, 32'h80000000, 32'h1};
    for (int i = 0; i < 9; i++) send_op(4'(i), vals[i % 6], vals[(i + 2) % 6]);
    send_op(fpa_pkg::ACT_DIV, 32'h0, 32'h0);
    send_op(fpa_pkg::ACT_DIV, 32'h80000000, 32'h0);
    send_op(fpa_pkg::ACT_DIV, 32'h100, 32'h0);
    send_op(fpa_pkg::ACT_MUL, 32'h180, 32'h1);        // rounding tie
    send_op(fpa_pkg::ACT_MUL, 32'hfffffe80, 32'h1);   // negative tie
    send_op(fpa_pkg::ACT_MUL, 32'h7fffffff, 32'h7fffffff);
    send_op(fpa_pkg::ACT_DIV, 32'h80000000, 32'hffffffff);
    send_op(fpa_pkg::ACT_INC, 32'h7fffffff, 32'h0);
    send_op(fpa_pkg::ACT_DEC, 32'h80000000, 32'h0);
    send_op(fpa_pkg::ACT_ADD, 32'h80000000, 32'h80000000);
    send_op(fpa_pkg::ACT_SUB, 32'h7fffffff, 32'h80000000);
    send_op(4'd9, 32'h5, 32'h5);
    send_op(4'd15, 32'hffffffff, 32'h0);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      send_op($urandom_range(0, 15) < 14 ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15)),
              rand_operand(), rand_operand());
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    test_random(100);
  endtask

  // receiver stall pattern plus one long hold-off on request
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (hold_req && !hold_taken) begin
      hold_taken <= 1;
      hold_off <= 300;
      m_axis_tready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= (cycles % 37 < 25) ? 1'b1 : ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk) begin
    alu_result_t got, exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.res = m_axis_tdata[31:0];
      got.lt  = m_axis_tdata[32];
      got.gt  = m_axis_tdata[33];
      got.eq  = m_axis_tdata[34];
      got.err = m_axis_tdata[35];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %h", m_axis_tdata);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp res=%h lt%b gt%b eq%b err%b, got res=%h lt%b gt%b eq%b err%b",
                     exp_r.res, exp_r.lt, exp_r.gt, exp_r.eq, exp_r.err,
                     got.res, got.lt, got.gt, got.eq, got.err);
        end
      end
    end
    if (cycles > 200000 && !done) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    test_directed();
    test_random(400);
    test_backpressure();
    test_random(400);
    s_axis_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    done = 1;
    if (mismatches == 0 && expected_q.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

/* files.f */
rtl/fpa_pkg.sv
rtl/fpa_mul.sv
rtl/fpa_div.sv
rtl/fixed_point_alu.sv
sim/tb_top.sv
